// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PXRLE_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define PXRLE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define PXRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pxrle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxrle_pkg
// Shared types, codes and helpers of the zero run-length sprite decoder.
// ----------------------------------------------------------------------------
package pxrle_pkg;

  localparam int MAX_DIMENSION   = 4096;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
  localparam int PAL_DATA_W      = 18;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 13;

  localparam logic [1:0] REQ_PALETTE = 2'd0;
  localparam logic [1:0] REQ_START   = 2'd1;
  localparam logic [1:0] REQ_DATA    = 2'd2;

  localparam logic RESULT_PIXEL  = 1'b0;
  localparam logic RESULT_FINISH = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_LEFT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_TOP      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_COLUMNS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_ROWS     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RLE_MODE      = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PIXEL,
    PH_SKIP,
    PH_RAW
  } phase_t;

  typedef struct packed {
    logic [12:0]        canvas_width;
    logic [12:0]        canvas_height;
    logic signed [12:0] area_left;
    logic signed [12:0] area_top;
    logic [11:0]        area_columns;
    logic [11:0]        area_rows;
    logic               rle_mode;
  } cfg_t;

  typedef struct packed {
    logic        pix;
    logic        fin;
    logic [11:0] px;
    logic [11:0] py;
  } dec_out_t;

  function automatic logic [7:0] widen(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

endpackage

// ===== hdl/pxrle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxrle_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pxrle_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pxrle_decoder.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pxrle_decoder
// Row/column tracking and byte parsing of the frame stream.
// ----------------------------------------------------------------------------
module pxrle_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  acc,
  input  logic [1:0]            req_type,
  input  logic [7:0]            data_byte,
  input  pxrle_pkg::cfg_t       cfg,
  output pxrle_pkg::dec_out_t   dec
);

  import pxrle_pkg::*;

  phase_t      phase, phase_next;
  logic [12:0] column_pos, column_pos_next;
  logic [11:0] row_pos, row_pos_next;
  logic [15:0] row_byte_count, row_byte_count_next;
  logic [15:0] row_length, row_length_next;

  logic               end_row;
  logic               emit_req;
  logic [15:0]        rbc_inc;
  logic [15:0]        len_full;
  logic [13:0]        skip_sum;
  logic [11:0]        row_inc;
  logic signed [14:0] tx;
  logic signed [14:0] ty;
  logic               on_canvas;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      column_pos     <= '0;
      row_pos        <= '0;
      row_byte_count <= '0;
      row_length     <= '0;
    end else if (acc) begin
      phase          <= phase_next;
      column_pos     <= column_pos_next;
      row_pos        <= row_pos_next;
      row_byte_count <= row_byte_count_next;
      row_length     <= row_length_next;
    end
  end

  always_comb begin
    tx = {{2{cfg.area_left[12]}}, cfg.area_left} + $signed({2'b00, column_pos});
    ty = {{2{cfg.area_top[12]}}, cfg.area_top} + $signed({3'b000, row_pos});
    on_canvas = !tx[14] && !ty[14]
             && ({1'b0, tx[13:0]} < {2'b00, cfg.canvas_width})
             && ({1'b0, ty[13:0]} < {2'b00, cfg.canvas_height})
             && ({17'd0, tx} < 32'(MAX_DIMENSION))
             && ({17'd0, ty} < 32'(MAX_DIMENSION));
    rbc_inc  = row_byte_count + 16'd1;
    len_full = row_length | {data_byte, 8'h00};
    skip_sum = {1'b0, column_pos} + {6'd0, data_byte};
    row_inc  = row_pos + 12'd1;

    phase_next          = phase;
    column_pos_next     = column_pos;
    row_pos_next        = row_pos;
    row_byte_count_next = row_byte_count;
    row_length_next     = row_length;
    end_row             = 1'b0;
    emit_req            = 1'b0;
    dec                 = '0;

    case (req_type)
      REQ_START: begin
        column_pos_next     = '0;
        row_pos_next        = '0;
        row_byte_count_next = '0;
        row_length_next     = '0;
        if (cfg.area_rows == 12'd0 || (!cfg.rle_mode && cfg.area_columns == 12'd0)) begin
          dec.fin    = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          phase_next = cfg.rle_mode ? PH_LEN_LO : PH_RAW;
        end
      end
      REQ_DATA: begin
        case (phase)
          PH_LEN_LO: begin
            row_length_next     = {8'h00, data_byte};
            row_byte_count_next = 16'd1;
            phase_next          = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            row_length_next     = (len_full < 16'd2) ? 16'd2 : len_full;
            row_byte_count_next = 16'd2;
            phase_next          = PH_PIXEL;
            end_row             = (row_length_next == 16'd2);
          end
          PH_PIXEL: begin
            row_byte_count_next = rbc_inc;
            if ({1'b0, column_pos} < {2'b00, cfg.area_columns}) begin
              if (data_byte == 8'd0) begin
                if (rbc_inc < row_length) begin
                  phase_next = PH_SKIP;
                end
              end else begin
                emit_req        = 1'b1;
                column_pos_next = column_pos + 13'd1;
              end
            end
            end_row = (phase_next == PH_PIXEL) && (rbc_inc >= row_length);
          end
          PH_SKIP: begin
            row_byte_count_next = rbc_inc;
            column_pos_next     = skip_sum[13] ? 13'h1FFF : skip_sum[12:0];
            phase_next          = PH_PIXEL;
            end_row             = (rbc_inc >= row_length);
          end
          PH_RAW: begin
            emit_req        = 1'b1;
            column_pos_next = column_pos + 13'd1;
            end_row         = (column_pos_next >= {1'b0, cfg.area_columns});
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (end_row) begin
      column_pos_next     = '0;
      row_byte_count_next = '0;
      row_length_next     = '0;
      row_pos_next        = row_inc;
      if (row_inc >= cfg.area_rows || row_inc == 12'd0) begin
        dec.fin    = 1'b1;
        phase_next = PH_IDLE;
      end else begin
        phase_next = (phase == PH_RAW) ? PH_RAW : PH_LEN_LO;
      end
    end

    dec.pix = emit_req && (data_byte != 8'd0) && on_canvas;
    dec.px  = tx[11:0];
    dec.py  = ty[11:0];
  end

  `PXRLE_ASSERT_IMPLY(a_idle_clean, phase == PH_IDLE, column_pos == 13'd0 && row_byte_count == 16'd0 && row_length == 16'd0, "idle with row state left over")
  `PXRLE_ASSERT_IMPLY(a_len_hi_count, phase == PH_LEN_HI, row_byte_count == 16'd1, "length high byte expected after one byte")
  `PXRLE_ASSERT_IMPLY(a_skip_in_row, phase == PH_SKIP, row_byte_count < row_length, "skip count beyond row end")

endmodule

// ===== hdl/palette_expand_rle_shape_decode_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// palette_expand_rle_shape_decode_core
// Results are valid in the cycle after the input transfer.
// Throughput: 1 item per cycle while out_ready is high; an item giving a
// pixel and a frame finish holds the input until its pixel result drains.
// The palette colour comes from the registered read port of the palette RAM.
// Reset: control state and config cleared (canvas 1x1), palette undefined.
// ----------------------------------------------------------------------------
module palette_expand_rle_shape_decode_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pxrle_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pxrle_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic [7:0]                          palette_slot,
  input  logic [5:0]                          red_six,
  input  logic [5:0]                          green_six,
  input  logic [5:0]                          blue_six,
  input  logic [7:0]                          data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                result_kind,
  output logic [11:0]                         pixel_x,
  output logic [11:0]                         pixel_y,
  output logic [7:0]                          red,
  output logic [7:0]                          green,
  output logic [7:0]                          blue,
  output logic                                last
);

  import pxrle_pkg::*;

  cfg_t                  cfg;
  dec_out_t              dec;
  logic                  acc;
  logic                  pix_pend;
  logic                  fin_pend;
  logic [11:0]           px;
  logic [11:0]           py;
  logic [PAL_DATA_W-1:0] pal_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canvas_width  <= 13'd1;
      cfg.canvas_height <= 13'd1;
      cfg.area_left     <= '0;
      cfg.area_top      <= '0;
      cfg.area_columns  <= '0;
      cfg.area_rows     <= '0;
      cfg.rle_mode      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  cfg.canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: cfg.canvas_height <= cfg_data;
        REG_AREA_LEFT:     cfg.area_left     <= cfg_data;
        REG_AREA_TOP:      cfg.area_top      <= cfg_data;
        REG_AREA_COLUMNS:  cfg.area_columns  <= cfg_data[11:0];
        REG_AREA_ROWS:     cfg.area_rows     <= cfg_data[11:0];
        REG_RLE_MODE:      cfg.rle_mode      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !(pix_pend || fin_pend) || (out_ready && !(pix_pend && fin_pend));
  assign acc      = in_valid && in_ready;

  pxrle_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .req_type  (req_type),
    .data_byte (data_byte),
    .cfg       (cfg),
    .dec       (dec)
  );

  pxrle_ram #(
    .WIDTH (PAL_DATA_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (acc && req_type == REQ_PALETTE),
    .waddr (palette_slot),
    .wdata ({blue_six, green_six, red_six}),
    .re    (acc),
    .raddr (data_byte),
    .rdata (pal_rdata)
  );

  // result stage: pixel drains first, then frame finish
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_pend <= 1'b0;
      fin_pend <= 1'b0;
    end else if (acc) begin
      pix_pend <= dec.pix;
      fin_pend <= dec.fin;
    end else if (out_valid && out_ready) begin
      if (pix_pend) begin
        pix_pend <= 1'b0;
      end else begin
        fin_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px <= dec.px;
      py <= dec.py;
    end
  end

  always_comb begin
    out_valid   = pix_pend || fin_pend;
    result_kind = pix_pend ? RESULT_PIXEL : RESULT_FINISH;
    pixel_x     = pix_pend ? px : 12'd0;
    pixel_y     = pix_pend ? py : 12'd0;
    red         = pix_pend ? widen(pal_rdata[5:0]) : 8'd0;
    green       = pix_pend ? widen(pal_rdata[11:6]) : 8'd0;
    blue        = pix_pend ? widen(pal_rdata[17:12]) : 8'd0;
    last        = !(pix_pend && fin_pend);
  end

  `PXRLE_ASSERT_IMPLY(a_full_stalls, pix_pend && fin_pend, !in_ready, "input taken with two results queued")
  `PXRLE_ASSERT_NEXT(a_pixel_follows, acc && dec.pix, pix_pend && out_valid, "pixel result lost after transfer")
  `PXRLE_ASSERT_IMPLY(a_last_flag, out_valid && !last, pix_pend && fin_pend, "last cleared without a second result")

endmodule

// ===== sim/palette_expand_rle_shape_decode_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_expand_rle_shape_decode_core_test
// Self-checking bench for the sprite frame decoder. A behavioral decoder in
// the bench tracks the palette, the frame position and the row parser, and
// predicts every pixel write and frame end. Directed tests cover clipping,
// row length corner cases, skips, restarts and area changes; random frames
// follow under random input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module palette_expand_rle_shape_decode_core_test;
  import pxrle_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int RANDOM_ITEMS         = 480;
  localparam int CYCLE_LIMIT          = 1_000_000;
  localparam int SETTLE_CYCLES        = 4;

  typedef struct packed {
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
  } pixel_write_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             req_type = REQ_UNUSED;
  logic [7:0]             palette_slot = '0;
  logic [5:0]             red_six = '0;
  logic [5:0]             green_six = '0;
  logic [5:0]             blue_six = '0;
  logic [7:0]             data_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   result_kind;
  logic [11:0]            pixel_x;
  logic [11:0]            pixel_y;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic                   last;

  palette_expand_rle_shape_decode_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state as seen by the bench
  logic [17:0]  pal_rgb [PALETTE_ENTRIES];
  phase_t       phase = PH_IDLE;
  int           col_pos = 0;
  int           row_idx = 0;
  int           row_bytes = 0;
  int           row_len = 0;
  int           canvas_w = 1;
  int           canvas_h = 1;
  int           off_x = 0;
  int           off_y = 0;
  int           area_cols = 0;
  int           area_row_cnt = 0;
  bit           rle_cfg = 1'b0;

  pixel_write_t predicted_writes [$];
  pixel_write_t step_out [2];
  int           step_n;

  int  errors = 0;
  int  decoded_items = 0;
  int  random_items = 0;
  int  pixels_seen = 0;
  int  frames_seen = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  steady = 1'b0;

  function automatic logic [7:0] expand6(logic [5:0] v);
    return (8'(v) << 2) | 8'(v >> 4);
  endfunction

  function automatic void add_result(logic kind, int x, int y, logic [17:0] rgb);
    pixel_write_t w;
    w.kind = kind;
    w.x = x[11:0];
    w.y = y[11:0];
    w.r = expand6(rgb[5:0]);
    w.g = expand6(rgb[11:6]);
    w.b = expand6(rgb[17:12]);
    w.last = 1'b0;
    step_out[step_n] = w;
    step_n++;
  endfunction

  function automatic void plot(logic [7:0] idx);
    int tx, ty;
    if (idx == 8'd0) return;
    tx = off_x + col_pos;
    ty = off_y + row_idx;
    if (tx < 0 || ty < 0 || tx >= canvas_w || ty >= canvas_h) return;
    if (tx >= MAX_DIMENSION || ty >= MAX_DIMENSION) return;
    add_result(RESULT_PIXEL, tx, ty, pal_rgb[idx]);
  endfunction

  function automatic void end_frame();
    add_result(RESULT_FINISH, 0, 0, 18'd0);
    phase = PH_IDLE;
  endfunction

  function automatic void next_row(bit rle);
    col_pos = 0;
    row_bytes = 0;
    row_len = 0;
    row_idx = (row_idx + 1) & 12'hFFF;
    if (row_idx >= area_row_cnt || row_idx == 0) end_frame();
    else phase = rle ? PH_LEN_LO : PH_RAW;
  endfunction

  function automatic void decode_item(logic [1:0] req, logic [7:0] slot, logic [5:0] r6,
                                      logic [5:0] g6, logic [5:0] b6, logic [7:0] db);
    int i;
    step_n = 0;
    case (req)
      REQ_PALETTE: begin
        pal_rgb[slot] = {b6, g6, r6};
        decoded_items++;
      end
      REQ_START: begin
        decoded_items++;
        col_pos = 0;
        row_idx = 0;
        row_bytes = 0;
        row_len = 0;
        if (area_row_cnt == 0 || (!rle_cfg && area_cols == 0)) end_frame();
        else phase = rle_cfg ? PH_LEN_LO : PH_RAW;
      end
      REQ_DATA: begin
        if (phase != PH_IDLE) decoded_items++;
        case (phase)
          PH_LEN_LO: begin
            row_len = db;
            row_bytes = 1;
            phase = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            row_len = row_len | (int'(db) << 8);
            if (row_len < 2) row_len = 2;
            row_bytes = 2;
            phase = PH_PIXEL;
            if (row_bytes >= row_len) next_row(1'b1);
          end
          PH_PIXEL: begin
            row_bytes = (row_bytes + 1) & 16'hFFFF;
            if (col_pos < area_cols) begin
              if (db == 8'd0) begin
                if (row_bytes < row_len) phase = PH_SKIP;
              end else begin
                plot(db);
                col_pos++;
              end
            end
            if (phase == PH_PIXEL && row_bytes >= row_len) next_row(1'b1);
          end
          PH_SKIP: begin
            row_bytes = (row_bytes + 1) & 16'hFFFF;
            col_pos = col_pos + db;
            if (col_pos > 8191) col_pos = 8191;
            phase = PH_PIXEL;
            if (row_bytes >= row_len) next_row(1'b1);
          end
          PH_RAW: begin
            plot(db);
            col_pos++;
            if (col_pos >= area_cols) next_row(1'b0);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    for (i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_out[i].last = 1'b1;
      predicted_writes.push_back(step_out[i]);
    end
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [12:0] v);
    case (idx)
      REG_CANVAS_WIDTH:  canvas_w = v;
      REG_CANVAS_HEIGHT: canvas_h = v;
      REG_AREA_LEFT:     off_x = $signed(v);
      REG_AREA_TOP:      off_y = $signed(v);
      REG_AREA_COLUMNS:  area_cols = v[11:0];
      REG_AREA_ROWS:     area_row_cnt = v[11:0];
      REG_RLE_MODE:      rle_cfg = v[0];
      default: ;
    endcase
  endfunction

  function automatic int pick_wait();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(9, 30);
  endfunction

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 99) < 55) return 0;
    return pick_wait();
  endfunction

  function automatic void compare_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endfunction

  // output back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      stall_left = pick_wait();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    pixel_write_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_writes.size() == 0) begin
        $error("unexpected result: kind %0d x %0d y %0d", result_kind, pixel_x, pixel_y);
        errors++;
      end else begin
        want = predicted_writes.pop_front();
        compare_field("result_kind", want.kind, result_kind);
        compare_field("pixel_x", want.x, pixel_x);
        compare_field("pixel_y", want.y, pixel_y);
        compare_field("red", want.r, red);
        compare_field("green", want.g, green);
        compare_field("blue", want.b, blue);
        compare_field("last", want.last, last);
        if (want.kind == RESULT_FINISH) frames_seen++;
        else pixels_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", predicted_writes.size());
      $display("[palette_expand_rle_shape_decode_core] ERROR");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] req, logic [7:0] slot, logic [5:0] r6, logic [5:0] g6,
                           logic [5:0] b6, logic [7:0] db);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    palette_slot <= slot;
    red_six <= r6;
    green_six <= g6;
    blue_six <= b6;
    data_byte <= db;
    do @(posedge clk); while (!in_ready);
    decode_item(req, slot, r6, g6, b6, db);
  endtask

  task automatic send_palette(logic [7:0] slot, logic [5:0] r6, logic [5:0] g6, logic [5:0] b6);
    send_item(REQ_PALETTE, slot, r6, g6, b6, 8'($urandom));
  endtask

  task automatic send_start();
    send_item(REQ_START, 8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom), 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] db);
    send_item(REQ_DATA, 8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom), db);
  endtask

  // drain all outstanding results with the input held idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int left, int top, int cols, int rows, int rle);
    logic [CFG_INDEX_W-1:0] idx [7];
    int val [7];
    int i;
    settle();
    idx = '{REG_CANVAS_WIDTH, REG_CANVAS_HEIGHT, REG_AREA_LEFT, REG_AREA_TOP,
            REG_AREA_COLUMNS, REG_AREA_ROWS, REG_RLE_MODE};
    val = '{w, h, left, top, cols, rows, rle};
    for (i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= 13'(val[i]);
      @(posedge clk);
      apply_reg(idx[i], 13'(val[i]));
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_palette_fill();
    int s;
    for (s = 0; s < PALETTE_ENTRIES; s++) begin
      if (s == 1) send_palette(8'(s), 6'h3F, 6'h3F, 6'h3F);
      else if (s == 2) send_palette(8'(s), 6'h00, 6'h00, 6'h00);
      else send_palette(8'(s), 6'($urandom), 6'($urandom), 6'($urandom));
    end
  endtask

  task automatic test_ignored_items();
    send_byte(8'hA5);
    send_item(REQ_UNUSED, 8'hFF, 6'h3F, 6'h3F, 6'h3F, 8'hFF);
    send_start();
    send_byte(8'h01);
  endtask

  task automatic test_raw_clipping();
    configure(4, 3, -1, 1, 3, 2, 0);
    send_start();
    send_byte(8'd1);
    send_byte(8'd255);
    send_byte(8'd0);
    send_byte(8'd2);
    send_byte(8'd255);
    send_byte(8'd1);
  endtask

  task automatic test_rle_rows();
    logic [7:0] stream [$] = '{8'h08, 8'h00, 8'h01, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00,
                               8'h01, 8'h00,
                               8'h04, 8'h00, 8'h05, 8'h00,
                               8'h06, 8'h00, 8'h00, 8'h09, 8'h03, 8'h04};
    configure(16, 16, 2, 3, 6, 4, 1);
    steady = 1'b1;
    send_start();
    foreach (stream[i]) send_byte(stream[i]);
    steady = 1'b0;
  endtask

  task automatic test_extremes();
    configure(4096, 4096, 4095, 4095, 4095, 4095, 1);
    send_start();
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h01);
    configure(4096, 4096, -4096, -4096, 1, 1, 0);
    send_start();
    send_byte(8'h01);
    configure(1, 1, 0, 0, 0, 5, 0);
    send_start();
    configure(1, 1, 0, 0, 0, 1, 1);
    send_start();
    send_byte(8'h02);
    send_byte(8'h00);
    configure(1, 1, 0, 0, 2, 1, 0);
    send_start();
    send_byte(8'h01);
    send_byte(8'h01);
  endtask

  task automatic test_restart();
    configure(8, 8, 0, 0, 4, 3, 0);
    send_start();
    send_byte(8'd1);
    send_byte(8'd2);
    send_start();
    repeat (4) send_byte(8'd1);
    configure(8, 8, 0, 0, 4, 3, 1);
    send_start();
    send_byte(8'h05);
    send_start();
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h07);
  endtask

  task automatic test_shrink_area();
    configure(8, 8, 0, 0, 5, 4, 0);
    send_start();
    repeat (3) send_byte(8'd1);
    configure(8, 8, 0, 0, 2, 1, 0);
    send_byte(8'd1);
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 1;
    if (r == 1) return 4096;
    return $urandom_range(1, 16);
  endfunction

  function automatic int pick_offset();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -4096;
    if (r == 1) return 4095;
    return int'($urandom_range(0, 12)) - 4;
  endfunction

  function automatic int pick_extent(int typical);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    return $urandom_range(1, typical);
  endfunction

  task automatic send_noise();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0)
      send_item(REQ_UNUSED, 8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom),
                8'($urandom));
    else if (r == 1) send_byte(8'($urandom));
    else send_palette(8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic send_rle_row();
    logic [7:0] body [$];
    int want, len, r;
    want = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 9);
    while (body.size() < want) begin
      if ($urandom_range(0, 99) < 25) begin
        body.push_back(8'd0);
        body.push_back(($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom));
      end else begin
        body.push_back(8'($urandom_range(1, 255)));
      end
    end
    len = body.size() + 2;
    r = $urandom_range(0, 99);
    if (r < 4) len = $urandom_range(0, 1);
    else if (r < 8) len = len + $urandom_range(1, 3);
    else if (r < 11) len = (len > 3) ? len - $urandom_range(1, 2) : len;
    else if (r < 13) len = $urandom_range(256, 65535);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (body[i]) begin
      if ($urandom_range(0, 32) == 0)
        send_palette(8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
      send_byte(body[i]);
    end
  endtask

  task automatic test_random_traffic();
    int base, rle, cols, rows, nrows, nbytes;
    base = decoded_items;
    while (decoded_items - base < RANDOM_ITEMS) begin
      rle = $urandom_range(0, 1);
      cols = pick_extent(8);
      rows = pick_extent(5);
      configure(pick_size(), pick_size(), pick_offset(), pick_offset(), cols, rows, rle);
      steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        send_start();
        if (rle != 0) begin
          nrows = (rows == 0) ? 1 : ((rows > 6) ? $urandom_range(1, 6) : rows);
          if ($urandom_range(0, 6) == 0) nrows = $urandom_range(1, nrows);
          repeat (nrows) send_rle_row();
        end else begin
          nbytes = (cols * rows > 40) ? 40 : cols * rows;
          if ($urandom_range(0, 6) == 0) nbytes = $urandom_range(0, nbytes);
          nbytes = nbytes + $urandom_range(0, 1);
          repeat (nbytes)
            send_byte(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom));
        end
      end
    end
    random_items = decoded_items - base;
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_palette_fill();
    test_ignored_items();
    test_raw_clipping();
    test_rle_rows();
    test_extremes();
    test_restart();
    test_shrink_area();
    test_random_traffic();
    settle();
    $display("Decoded %0d items, %0d of them in random frames under gaps and stalls.",
             decoded_items, random_items);
    $display("Checked %0d pixel writes and %0d frame ends.", pixels_seen, frames_seen);
    if (errors == 0) begin
      $display("[palette_expand_rle_shape_decode_core] OK");
    end else begin
      $display("[palette_expand_rle_shape_decode_core] ERROR");
    end
    $finish;
  end

endmodule
